// ----- rtl/line_rasterizer_defines.svh -----
// Assertion macros for the line rasterizer RTL.
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LR_ASSERT_NEVER(lbl, cond, msg) \
    `LR_ASSERT(lbl, !(cond), msg)
`else
`define LR_ASSERT(lbl, prop, msg)
`define LR_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- rtl/lr_pkg.sv -----
// Types and constants shared by the line rasterizer modules.
`default_nettype none

package lr_pkg;

    localparam int COLOR_BITS = 24;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } lr_op_t;

    typedef struct packed
    {
        logic busy;
        logic minor_down;
        logic steep;
    } lr_flags_t;

endpackage

`default_nettype wire

// ----- rtl/lr_step.sv -----
// Next-state and pixel logic of the Bresenham rasterizer for one item.
`default_nettype none

module lr_step
    import lr_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  lr_op_t                         op,
    input  logic [COORD_BITS-1:0]          x_start,
    input  logic [COORD_BITS-1:0]          y_start,
    input  logic [COORD_BITS-1:0]          x_end,
    input  logic [COORD_BITS-1:0]          y_end,
    input  logic [COORD_BITS-1:0]          cur_x,
    input  logic [COORD_BITS-1:0]          cur_y,
    input  logic [COORD_BITS-1:0]          major_stop,
    input  logic signed [COORD_BITS+2:0]   err_term,
    input  logic [COORD_BITS-1:0]          delta_major,
    input  logic [COORD_BITS-1:0]          delta_minor,
    input  lr_flags_t                      flags,
    output logic [COORD_BITS-1:0]          cur_x_next,
    output logic [COORD_BITS-1:0]          cur_y_next,
    output logic [COORD_BITS-1:0]          major_stop_next,
    output logic signed [COORD_BITS+2:0]   err_term_next,
    output logic [COORD_BITS-1:0]          delta_major_next,
    output logic [COORD_BITS-1:0]          delta_minor_next,
    output lr_flags_t                      flags_next,
    output logic                           emit,
    output logic                           last
);

    localparam int CW = COORD_BITS;
    localparam int EW = COORD_BITS + 3;

    logic [CW-1:0]        adx;
    logic [CW-1:0]        ady;
    logic                 ld_steep;
    logic [CW-1:0]        mj0;
    logic [CW-1:0]        mj1;
    logic [CW-1:0]        mn0;
    logic [CW-1:0]        mn1;
    logic [CW-1:0]        a_mj0;
    logic [CW-1:0]        a_mj1;
    logic [CW-1:0]        a_mn0;
    logic [CW-1:0]        a_mn1;
    logic                 ld_down;
    logic [CW-1:0]        ld_dmaj;
    logic [CW-1:0]        ld_dmin;
    logic signed [EW-1:0] ld_err;
    logic [CW-1:0]        st_mj;
    logic [CW-1:0]        st_mn;
    logic [CW-1:0]        st_mj_nx;
    logic [CW-1:0]        st_mn_nx;
    logic signed [EW-1:0] twice_dmin;
    logic signed [EW-1:0] twice_dmaj;
    logic signed [EW-1:0] st_err;
    logic                 st_last;

    // Load path: order the endpoints so the major coordinate ascends.
    always_comb
    begin
        adx      = (x_end >= x_start) ? x_end - x_start : x_start - x_end;
        ady      = (y_end >= y_start) ? y_end - y_start : y_start - y_end;
        ld_steep = (ady >= adx);
        mj0      = ld_steep ? y_start : x_start;
        mj1      = ld_steep ? y_end   : x_end;
        mn0      = ld_steep ? x_start : y_start;
        mn1      = ld_steep ? x_end   : y_end;
        if (mj1 < mj0)
        begin
            a_mj0 = mj1;
            a_mj1 = mj0;
            a_mn0 = mn1;
            a_mn1 = mn0;
        end
        else
        begin
            a_mj0 = mj0;
            a_mj1 = mj1;
            a_mn0 = mn0;
            a_mn1 = mn1;
        end
        ld_dmaj = a_mj1 - a_mj0;
        ld_down = (a_mn1 < a_mn0);
        ld_dmin = ld_down ? a_mn0 - a_mn1 : a_mn1 - a_mn0;
        ld_err  = $signed({2'b00, ld_dmin, 1'b0}) - $signed({3'b000, ld_dmaj});
    end

    // Step path: one pixel along the major axis.
    always_comb
    begin
        st_mj      = flags.steep ? cur_y : cur_x;
        st_mn      = flags.steep ? cur_x : cur_y;
        twice_dmin = $signed({2'b00, delta_minor, 1'b0});
        twice_dmaj = $signed({2'b00, delta_major, 1'b0});
        if (err_term > $signed({EW{1'b0}}))
        begin
            st_mn_nx = flags.minor_down ? st_mn - 1'b1 : st_mn + 1'b1;
            st_err   = err_term + (twice_dmin - twice_dmaj);
        end
        else
        begin
            st_mn_nx = st_mn;
            st_err   = err_term + twice_dmin;
        end
        st_mj_nx = st_mj + 1'b1;
        st_last  = (st_mj_nx == major_stop);
    end

    always_comb
    begin
        cur_x_next       = cur_x;
        cur_y_next       = cur_y;
        major_stop_next  = major_stop;
        err_term_next    = err_term;
        delta_major_next = delta_major;
        delta_minor_next = delta_minor;
        flags_next       = flags;
        emit             = 1'b0;
        last             = 1'b0;
        case (op)
            OP_LOAD:
            begin
                cur_x_next            = ld_steep ? a_mn0 : a_mj0;
                cur_y_next            = ld_steep ? a_mj0 : a_mn0;
                major_stop_next       = a_mj1;
                err_term_next         = ld_err;
                delta_major_next      = ld_dmaj;
                delta_minor_next      = ld_dmin;
                last                  = (ld_dmaj == '0);
                flags_next.busy       = (ld_dmaj != '0);
                flags_next.minor_down = ld_down;
                flags_next.steep      = ld_steep;
                emit                  = 1'b1;
            end
            OP_STEP:
            begin
                if (flags.busy)
                begin
                    cur_x_next      = flags.steep ? st_mn_nx : st_mj_nx;
                    cur_y_next      = flags.steep ? st_mj_nx : st_mn_nx;
                    err_term_next   = st_err;
                    flags_next.busy = !st_last;
                    last            = st_last;
                    emit            = 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/line_rasterizer.sv -----
// Bresenham line rasterizer: loads a line and emits one pixel per item while a line is open.
//
// Input channel s_axis: tuser selects the operation. A load item carries both
// endpoints and the colour, and yields the line's first pixel. A step item
// yields the next pixel of the current line, or nothing when no line is open.
// A load while a line is open abandons it.
// Output channel m_axis: at most one pixel per item, tlast high on the final pixel.
// An accepted item lands in the input register; once the result register is
// free or being taken, the pixel and the new line state are computed from it
// and loaded into the result register, which then presents the pixel.
// Throughput is one item per cycle unless m_axis stalls: the line state is one
// add and one compare away from the next pixel, so steps follow each other with no gap.
// When m_axis stalls, the pending pixel holds in the result register and the
// input register still takes one more item; s_axis_tready then falls until
// the receiver takes the pixel.
// Reset empties both registers and closes any open line.
`default_nettype none
`include "line_rasterizer_defines.svh"

module line_rasterizer
    import lr_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // x_start, y_start, x_end, y_end, line_color from bit 0 up, zero padded
    input  logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
    // opcode
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pixel_x, pixel_y, pixel_color from bit 0 up, zero padded
    output logic [((2*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    localparam int CW      = COORD_BITS;
    localparam int EW      = COORD_BITS + 3;
    localparam int IN_BITS = 4 * COORD_BITS + COLOR_BITS;

    logic                 in_vld_reg;
    lr_op_t               in_op_reg;
    logic [IN_BITS-1:0]   in_data_reg;
    logic                 advance;

    logic [CW-1:0]        cur_x_reg;
    logic [CW-1:0]        cur_y_reg;
    logic [CW-1:0]        major_stop_reg;
    logic signed [EW-1:0] err_term_reg;
    logic [CW-1:0]        delta_major_reg;
    logic [CW-1:0]        delta_minor_reg;
    logic [COLOR_BITS-1:0] held_color_reg;
    lr_flags_t            flags_reg;

    logic [CW-1:0]        cur_x_next;
    logic [CW-1:0]        cur_y_next;
    logic [CW-1:0]        major_stop_next;
    logic signed [EW-1:0] err_term_next;
    logic [CW-1:0]        delta_major_next;
    logic [CW-1:0]        delta_minor_next;
    logic [COLOR_BITS-1:0] held_color_next;
    lr_flags_t            flags_next;
    logic                 emit;
    logic                 pix_last;

    logic                 out_vld_reg;
    logic [CW-1:0]        pix_x_reg;
    logic [CW-1:0]        pix_y_reg;
    logic [COLOR_BITS-1:0] pix_color_reg;
    logic                 pix_last_reg;

    assign advance       = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg   <= lr_op_t'(s_axis_tuser);
            in_data_reg <= s_axis_tdata[IN_BITS-1:0];
        end
    end

    lr_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .op               (in_op_reg),
        .x_start          (in_data_reg[CW-1:0]),
        .y_start          (in_data_reg[2*CW-1:CW]),
        .x_end            (in_data_reg[3*CW-1:2*CW]),
        .y_end            (in_data_reg[4*CW-1:3*CW]),
        .cur_x            (cur_x_reg),
        .cur_y            (cur_y_reg),
        .major_stop       (major_stop_reg),
        .err_term         (err_term_reg),
        .delta_major      (delta_major_reg),
        .delta_minor      (delta_minor_reg),
        .flags            (flags_reg),
        .cur_x_next       (cur_x_next),
        .cur_y_next       (cur_y_next),
        .major_stop_next  (major_stop_next),
        .err_term_next    (err_term_next),
        .delta_major_next (delta_major_next),
        .delta_minor_next (delta_minor_next),
        .flags_next       (flags_next),
        .emit             (emit),
        .last             (pix_last)
    );

    assign held_color_next = (in_op_reg == OP_LOAD) ? in_data_reg[IN_BITS-1:4*CW]
                                                    : held_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                flags_reg   <= flags_next;
                out_vld_reg <= emit;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Line state is only read while the line is open, so it needs no reset.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            major_stop_reg  <= major_stop_next;
            err_term_reg    <= err_term_next;
            delta_major_reg <= delta_major_next;
            delta_minor_reg <= delta_minor_next;
            held_color_reg  <= held_color_next;
        end
        if (advance && emit)
        begin
            pix_x_reg     <= cur_x_next;
            pix_y_reg     <= cur_y_next;
            pix_color_reg <= held_color_next;
            pix_last_reg  <= pix_last;
        end
    end

    always_comb
    begin
        m_axis_tdata                              = '0;
        m_axis_tdata[CW-1:0]                      = pix_x_reg;
        m_axis_tdata[2*CW-1:CW]                   = pix_y_reg;
        m_axis_tdata[2*CW+COLOR_BITS-1:2*CW]      = pix_color_reg;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tlast  = pix_last_reg;

    `LR_ASSERT_NEVER(a_ready_when_full, in_vld_reg && out_vld_reg && !m_axis_tready && s_axis_tready, "input taken while both registers are held")
    `LR_ASSERT(a_last_closes_line, advance && emit && pix_last |=> !flags_reg.busy, "line still open after its last pixel")
    `LR_ASSERT_NEVER(a_open_at_stop, flags_reg.busy && ((flags_reg.steep ? cur_y_reg : cur_x_reg) == major_stop_reg), "open line already at its final major coordinate")
    `LR_ASSERT(a_steep_step, advance && in_op_reg == OP_STEP && flags_reg.busy && flags_reg.steep |=> cur_y_reg == $past(cur_y_reg) + 1'b1, "steep step did not advance the row by one")

endmodule

`default_nettype wire
